FILE: src/gbc_pkg.sv
// Package with shared types, op codes and constants of the gesture box classifier.
package gbc_pkg;

    localparam int SampleBits  = 10;
    localparam int NumChannels = 11;
    localparam int LowChannels = 6;
    localparam int BoundBits   = 12;

    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_TRAIN    = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    localparam logic REG_TRAIN_MARGIN = 1'b0;
    localparam logic REG_STABLE_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  label;
        logic [59:0] samples_low;
        logic [49:0] samples_high;
    } in_item_t;

    typedef struct packed {
        logic       stable;
        logic       matched;
        logic [7:0] match_label;
        logic       announce;
        logic       train_full;
        logic       remove_missing;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture request, update averages on classify
        logic clr_scan;   // reset entry index
        logic next_entry; // advance entry index
        logic do_swap;    // swap current entry with the previous one
        logic do_widen;   // widen current entry box
        logic do_append;  // write new entry at the end
        logic do_shift;   // move entry index+1 down to index
        logic dec_count;  // drop last entry
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       stable;
        logic       at_end;     // index reached entry count
        logic       last_shift; // index+1 reached entry count
        logic       first;      // index is the first entry
        logic       hit_box;    // current entry holds the sample
        logic       hit_label;  // current entry carries the request label
        logic       full;
        logic [1:0] op;
    } status_t;

endpackage

FILE: src/gbc_datapath.sv
// Datapath: averages, entry table and per-entry box compare.
module gbc_datapath #(
    parameter int MaxGestures = 16,
    parameter int IdxBits     = 4,
    parameter int CntBits     = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gbc_pkg::in_item_t req,
    input  gbc_pkg::cmd_t    cmd,
    input  logic [7:0]       train_margin,
    input  logic [9:0]       stable_limit,
    output gbc_pkg::status_t status,
    output logic [7:0]       entry_label
);
    localparam int NC = gbc_pkg::NumChannels;
    localparam int SB = gbc_pkg::SampleBits;
    localparam int BB = gbc_pkg::BoundBits;

    typedef logic [NC*BB-1:0] box_t;

    logic [SB-1:0]      avg_reg [NC];
    logic [SB-1:0]      x_reg   [NC];
    logic               stable_reg;
    logic [1:0]         op_reg;
    logic [7:0]         label_reg;
    logic [CntBits-1:0] idx_reg;
    logic [CntBits-1:0] count_reg;

    // Entry table; contents are undefined until written.
    box_t       lo_mem  [MaxGestures];
    box_t       hi_mem  [MaxGestures];
    logic [7:0] lab_mem [MaxGestures];

    logic [SB-1:0]      x_in [NC];
    logic [SB-1:0]      avg_next [NC];
    logic [NC-1:0]      ch_ok;
    logic [IdxBits-1:0] ia, ib;
    logic [CntBits-1:0] idx_p1;
    box_t               lo_cur, hi_cur;
    logic [NC-1:0]      in_box;

    // Unpack the request channels.
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (c < gbc_pkg::LowChannels)
            begin
                x_in[c] = (c * SB + SB <= 60) ? req.samples_low[c*SB +: SB] : '0;
            end
            else
            begin
                x_in[c] = ((c - gbc_pkg::LowChannels) * SB + SB <= 50) ?
                          req.samples_high[(c-gbc_pkg::LowChannels)*SB +: SB] : '0;
            end
        end
    end

    // New averages (5*avg+x)/6 and stability check, one lane per channel.
    always_comb
    begin
        logic [SB+2:0] s;
        logic [SB+2:0] q;
        logic [SB:0]   d;
        for (int c = 0; c < NC; c++)
        begin
            s = {3'b000, avg_reg[c]} * (SB+3)'(5) + {3'b000, x_in[c]};
            q = (SB+3)'(((SB+18)'(s) * (SB+18)'(43691)) >> 18);
            avg_next[c] = q[SB-1:0];
            d = (avg_next[c] >= x_in[c]) ? {1'b0, avg_next[c] - x_in[c]}
                                         : {1'b0, x_in[c] - avg_next[c]};
            ch_ok[c] = (d <= (SB+1)'(stable_limit));
        end
    end

    assign idx_p1 = idx_reg + CntBits'(1);
    assign ia     = idx_reg[IdxBits-1:0];
    assign ib     = (cmd.do_swap) ? (idx_reg[IdxBits-1:0] - IdxBits'(1)) : idx_p1[IdxBits-1:0];
    assign lo_cur = lo_mem[ia];
    assign hi_cur = hi_mem[ia];
    assign entry_label = lab_mem[ia];

    // Box compare of the current entry, signed 12-bit bounds.
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            in_box[c] = ($signed({2'b00, x_reg[c]}) >= $signed(lo_cur[c*BB +: BB])) &&
                        ($signed({2'b00, x_reg[c]}) <= $signed(hi_cur[c*BB +: BB]));
        end
    end

    assign status.stable     = stable_reg;
    assign status.at_end     = (idx_reg == count_reg);
    assign status.last_shift = (idx_p1 >= count_reg);
    assign status.first      = (idx_reg == '0);
    assign status.hit_box    = &in_box;
    assign status.hit_label  = (lab_mem[ia] == label_reg);
    assign status.full       = (count_reg >= CntBits'(MaxGestures));
    assign status.op         = op_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                avg_reg[c] <= '0;
            end
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.load && req.op == gbc_pkg::OP_CLASSIFY)
            begin
                for (int c = 0; c < NC; c++)
                begin
                    avg_reg[c] <= avg_next[c];
                end
            end
            if (cmd.clr_scan)
            begin
                idx_reg <= '0;
            end
            else if (cmd.next_entry || cmd.do_shift)
            begin
                idx_reg <= idx_p1;
            end
            if (cmd.do_append)
            begin
                count_reg <= count_reg + CntBits'(1);
            end
            else if (cmd.dec_count)
            begin
                count_reg <= count_reg - CntBits'(1);
            end
        end
    end

    // Payload registers and the entry table.
    always_ff @(posedge clk)
    begin
        logic signed [BB-1:0] xv, m, lo_n, hi_n;
        box_t lo_w, hi_w;
        if (cmd.load)
        begin
            for (int c = 0; c < NC; c++)
            begin
                x_reg[c] <= x_in[c];
            end
            stable_reg <= &ch_ok;
            op_reg     <= req.op;
            label_reg  <= req.label;
        end
        m = $signed({4'b0000, train_margin});
        lo_w = lo_cur;
        hi_w = hi_cur;
        for (int c = 0; c < NC; c++)
        begin
            xv = $signed({2'b00, x_reg[c]});
            lo_n = xv - m;
            hi_n = xv + m;
            if (cmd.do_append || lo_n < $signed(lo_cur[c*BB +: BB]))
            begin
                lo_w[c*BB +: BB] = lo_n;
            end
            if (cmd.do_append || hi_n > $signed(hi_cur[c*BB +: BB]))
            begin
                hi_w[c*BB +: BB] = hi_n;
            end
        end
        if (cmd.do_widen)
        begin
            lo_mem[ia] <= lo_w;
            hi_mem[ia] <= hi_w;
        end
        else if (cmd.do_append)
        begin
            lo_mem[count_reg[IdxBits-1:0]]  <= lo_w;
            hi_mem[count_reg[IdxBits-1:0]]  <= hi_w;
            lab_mem[count_reg[IdxBits-1:0]] <= label_reg;
        end
        else if (cmd.do_swap || cmd.do_shift)
        begin
            lo_mem[ia]  <= lo_mem[ib];
            hi_mem[ia]  <= hi_mem[ib];
            lab_mem[ia] <= lab_mem[ib];
            lo_mem[ib]  <= lo_cur;
            hi_mem[ib]  <= hi_cur;
            lab_mem[ib] <= lab_mem[ia];
        end
    end
endmodule

FILE: src/gbc_ctrl.sv
// Controller: sequences one request through the entry walk and drives the result.
module gbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gbc_pkg::cmd_t     cmd,
    input  gbc_pkg::status_t  status,
    input  logic [7:0]        entry_label,
    output gbc_pkg::out_item_t out_item
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_SHIFT, S_OUT
    } state_t;

    state_t state_reg;
    logic announced_reg;
    gbc_pkg::out_item_t res_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_item  = res_reg;

    // Command decode.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load     = in_valid;
                cmd.clr_scan = in_valid;
            end
            S_SCAN:
            begin
                if (!status.at_end)
                begin
                    if (status.op == gbc_pkg::OP_CLASSIFY)
                    begin
                        if (status.hit_box)
                        begin
                            cmd.do_swap = !status.first;
                        end
                        else
                        begin
                            cmd.next_entry = 1'b1;
                        end
                    end
                    else if (status.hit_label)
                    begin
                        cmd.do_widen = (status.op == gbc_pkg::OP_TRAIN);
                    end
                    else
                    begin
                        cmd.next_entry = 1'b1;
                    end
                end
                else if (status.op == gbc_pkg::OP_TRAIN && !status.full)
                begin
                    cmd.do_append = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (status.last_shift)
                begin
                    cmd.dec_count = 1'b1;
                end
                else
                begin
                    cmd.do_shift = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            announced_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_reg   <= '0;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (status.op == gbc_pkg::OP_CLASSIFY && !status.stable)
                    begin
                        announced_reg <= 1'b0;
                        state_reg     <= S_OUT;
                    end
                    else if (status.op == gbc_pkg::OP_NONE)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (status.at_end)
                    begin
                        res_reg.stable         <= (status.op == gbc_pkg::OP_CLASSIFY);
                        res_reg.train_full     <= (status.op == gbc_pkg::OP_TRAIN) && status.full;
                        res_reg.remove_missing <= (status.op == gbc_pkg::OP_REMOVE);
                        state_reg              <= S_OUT;
                    end
                    else if (status.op == gbc_pkg::OP_CLASSIFY && status.hit_box)
                    begin
                        // Swap with the previous entry happens on this edge when not first.
                        res_reg.stable      <= 1'b1;
                        res_reg.matched     <= 1'b1;
                        res_reg.match_label <= entry_label;
                        res_reg.announce    <= !announced_reg;
                        announced_reg       <= 1'b1;
                        state_reg           <= S_OUT;
                    end
                    else if (status.op != gbc_pkg::OP_CLASSIFY && status.hit_label)
                    begin
                        state_reg <= (status.op == gbc_pkg::OP_TRAIN) ? S_OUT : S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (status.last_shift)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: src/gesture_box_classifier.sv
// Top level of the gesture box classifier.
// Usage: a request (op, label, eleven packed 10-bit channels) enters on the in
// channel with valid/ready; one result leaves on the out channel per request.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data; index 0
// is train_margin, index 1 is stable_limit. Write only while the block is idle.
// From acceptance to result valid: an unstable classify or an ignored op goes
// from the decide state straight to the result; a stable classify walks the
// stored entries, one compared per cycle, until a box holds the sample; train
// walks to the entry with its label and widens that box, or at the end appends
// a new entry when the table is not full; remove walks to the label and then
// shifts the rest down, one entry a cycle. One request is in work at a time;
// the next is taken the cycle after the result has been accepted.
// Reset clears the averages, entry count and announce latch, and sets the state,
// index, result and config registers to defaults; the entry table needs no clearing.
// When the receiver stalls, the result is held and in_ready stays low.
module gesture_box_classifier #(
    parameter int MAX_GESTURES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gbc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output gbc_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [9:0]         cfg_data
);
    localparam int IdxBits = (MAX_GESTURES > 1) ? $clog2(MAX_GESTURES) : 1;
    localparam int CntBits = $clog2(MAX_GESTURES + 1);

    logic [7:0] margin_reg;
    logic [9:0] limit_reg;
    gbc_pkg::cmd_t    cmd;
    gbc_pkg::status_t status;
    logic [7:0]       entry_label;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= 8'd15;
            limit_reg  <= 10'd8;
        end
        else if (cfg_we)
        begin
            if (cfg_index == gbc_pkg::REG_TRAIN_MARGIN)
            begin
                margin_reg <= cfg_data[7:0];
            end
            else
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    gbc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .status      (status),
        .entry_label (entry_label),
        .out_item    (out_data)
    );

    gbc_datapath #(
        .MaxGestures (MAX_GESTURES),
        .IdxBits     (IdxBits),
        .CntBits     (CntBits)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (in_data),
        .cmd          (cmd),
        .train_margin (margin_reg),
        .stable_limit (limit_reg),
        .status       (status),
        .entry_label  (entry_label)
    );

    // Results only while no request is being accepted.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("ready and result valid together");
    a_match_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.matched |-> out_data.stable)
        else $error("match without stable");
    a_label_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.matched |-> out_data.match_label == 8'd0)
        else $error("label without match");
endmodule
